// File: hw/rtl/mbrw_pkg.sv
// shared constants and types for the macroblock to raster writer
`timescale 1ns / 1ps
package mbrw_pkg;

    localparam int unsigned MB_SIZE      = 16;
    localparam int unsigned CHROMA_SIZE  = MB_SIZE / 2;
    localparam int unsigned LUMA_BYTES   = MB_SIZE * MB_SIZE;
    localparam int unsigned CHROMA_BYTES = CHROMA_SIZE * CHROMA_SIZE;
    localparam int unsigned MB_BYTES     = LUMA_BYTES + 2 * CHROMA_BYTES;

    localparam int unsigned IDX_W     = 9;
    localparam int unsigned BLK_W     = 4;
    localparam int unsigned CFG_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned SIZE_W    = CFG_W + 1;
    localparam int unsigned ADDR_W    = 22;
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned PLANE_W   = 2;

    localparam logic [IDX_W-1:0] LAST_SAMPLE = IDX_W'(MB_BYTES - 1);

    localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_CB   = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_CR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PICTURE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PICTURE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE    = 2'd2;

    // where the current sample lands inside its macroblock
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [BLK_W-1:0]   blk_row;
        logic [BLK_W-1:0]   blk_col;
        logic               frame_end;
    } mbrw_pos_t;

endpackage

// File: hw/rtl/mbrw_sample_if.sv
// input channel carrying decoded sample bytes
`timescale 1ns / 1ps
interface mbrw_sample_if
    import mbrw_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] sample_byte;

    modport source (output valid, output sample_byte, input ready);
    modport sink (input valid, input sample_byte, output ready);
endinterface

// File: hw/rtl/mbrw_raster_if.sv
// output channel carrying frame buffer writes
`timescale 1ns / 1ps
interface mbrw_raster_if
    import mbrw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PLANE_W-1:0] plane;
    logic [ADDR_W-1:0]  buffer_address;
    logic [PIX_W-1:0]   pixel_value;
    logic               frame_end;

    modport source (output valid, output plane, output buffer_address, output pixel_value,
                    output frame_end, input ready);
    modport sink (input valid, input plane, input buffer_address, input pixel_value,
                  input frame_end, output ready);
endinterface

// File: hw/rtl/mbrw_position.sv
// sample index and macroblock column and row counters
`timescale 1ns / 1ps
module mbrw_position
    import mbrw_pkg::*;
#(
    parameter int unsigned MAX_MBS = 128,
    localparam int unsigned CW = (MAX_MBS > 1) ? $clog2(MAX_MBS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [CFG_W-1:0] picture_width_mbs,
    input  logic [CFG_W-1:0] picture_height_mbs,
    output logic [CW-1:0]    mb_column,
    output logic [CW-1:0]    mb_row,
    output mbrw_pos_t        pos
);

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_MBS);
    localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(1);

    logic [IDX_W-1:0]  sample_index_reg, sample_index_next;
    logic [CW-1:0]     mb_column_reg, mb_column_next;
    logic [CW-1:0]     mb_row_reg, mb_row_next;
    logic [SIZE_W-1:0] width_clamped, height_clamped;
    logic              luma;
    logic              last_sample;
    logic              column_wrap;
    logic              row_wrap;

    always_comb
    begin
        if (picture_width_mbs == '0)
            width_clamped = MIN_SIZE;
        else if ({1'b0, picture_width_mbs} > MAX_SIZE)
            width_clamped = MAX_SIZE;
        else
            width_clamped = {1'b0, picture_width_mbs};

        if (picture_height_mbs == '0)
            height_clamped = MIN_SIZE;
        else if ({1'b0, picture_height_mbs} > MAX_SIZE)
            height_clamped = MAX_SIZE;
        else
            height_clamped = {1'b0, picture_height_mbs};
    end

    // a shrunk size wraps the position at the end of this macroblock
    assign column_wrap = (SIZE_W'(mb_column_reg) + SIZE_W'(1)) >= width_clamped;
    assign row_wrap    = (SIZE_W'(mb_row_reg) + SIZE_W'(1)) >= height_clamped;
    assign last_sample = sample_index_reg == LAST_SAMPLE;

    // luma 0..255, cb 256..319, cr 320..383
    assign luma = !sample_index_reg[8];

    always_comb
    begin
        pos.plane     = luma ? PLANE_LUMA : (sample_index_reg[6] ? PLANE_CR : PLANE_CB);
        pos.blk_row   = luma ? sample_index_reg[7:4] : {1'b0, sample_index_reg[5:3]};
        pos.blk_col   = luma ? sample_index_reg[3:0] : {1'b0, sample_index_reg[2:0]};
        pos.frame_end = last_sample && column_wrap && row_wrap;
    end

    always_comb
    begin
        sample_index_next = sample_index_reg;
        mb_column_next    = mb_column_reg;
        mb_row_next       = mb_row_reg;
        if (step)
        begin
            if (last_sample)
            begin
                sample_index_next = '0;
                if (column_wrap)
                begin
                    mb_column_next = '0;
                    mb_row_next    = row_wrap ? '0 : mb_row_reg + 1'b1;
                end
                else
                begin
                    mb_column_next = mb_column_reg + 1'b1;
                end
            end
            else
            begin
                sample_index_next = sample_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            mb_column_reg    <= '0;
            mb_row_reg       <= '0;
        end
        else
        begin
            sample_index_reg <= sample_index_next;
            mb_column_reg    <= mb_column_next;
            mb_row_reg       <= mb_row_next;
        end
    end

    assign mb_column = mb_column_reg;
    assign mb_row    = mb_row_reg;

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        sample_index_reg <= LAST_SAMPLE)
        else $error("sample index past end of macroblock");

    a_index_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_sample |=> sample_index_reg == '0)
        else $error("sample index did not wrap after last sample");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        step && pos.frame_end |=> mb_column_reg == '0 && mb_row_reg == '0)
        else $error("position not back at top left after frame end");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(sample_index_reg) && $stable(mb_column_reg) && $stable(mb_row_reg))
        else $error("position moved without a transaction");

endmodule

// File: hw/rtl/mbrw_address.sv
// planar frame buffer byte offset for the current sample
`timescale 1ns / 1ps
module mbrw_address
    import mbrw_pkg::*;
#(
    parameter int unsigned MAX_MBS = 128,
    localparam int unsigned CW = (MAX_MBS > 1) ? $clog2(MAX_MBS) : 1
)
(
    input  logic [CW-1:0]     mb_column,
    input  logic [CW-1:0]     mb_row,
    input  logic [CFG_W-1:0]  line_stride_mbs,
    input  mbrw_pos_t         pos,
    output logic [ADDR_W-1:0] buffer_address
);

    localparam int unsigned LINE_W   = CW + BLK_W;
    localparam int unsigned STRIDE_W = CFG_W + BLK_W;
    localparam int unsigned PROD_W   = LINE_W + STRIDE_W;

    logic                luma;
    logic [LINE_W-1:0]   line_num;
    logic [STRIDE_W-1:0] stride_bytes;
    logic [LINE_W-1:0]   column_offset;
    logic [PROD_W-1:0]   line_offset;

    assign luma = pos.plane == PLANE_LUMA;

    // chroma planes are half size in both directions
    always_comb
    begin
        if (luma)
        begin
            line_num      = {mb_row, pos.blk_row};
            stride_bytes  = {line_stride_mbs, 4'b0000};
            column_offset = {mb_column, pos.blk_col};
        end
        else
        begin
            line_num      = {1'b0, mb_row, pos.blk_row[2:0]};
            stride_bytes  = {1'b0, line_stride_mbs, 3'b000};
            column_offset = {1'b0, mb_column, pos.blk_col[2:0]};
        end
    end

    assign line_offset    = PROD_W'(line_num) * PROD_W'(stride_bytes);
    assign buffer_address = ADDR_W'(line_offset) + ADDR_W'(column_offset);

endmodule

// File: hw/rtl/macroblock_to_raster_writer_core.sv
// top level of the macroblock to raster writer
//
//   channel   dir   handshake      payload
//   samples   in    valid/ready    sample_byte[7:0]
//   pixels    out   valid/ready    plane[1:0], buffer_address[21:0],
//                                  pixel_value[7:0], frame_end
//   cfg       in    cfg_we         cfg_index[1:0], cfg_data[7:0]
//
// one transaction per cycle when pixels.ready holds; the result of a sample shows in
// the cycle after it is taken, from the output register
// the address is one 11 by 12 multiply and an add on the position counters
// a stalled output register takes a new sample in the cycle it is emptied
// reset clears the position to the top left macroblock and all sizes to one
`timescale 1ns / 1ps
module macroblock_to_raster_writer_core
    import mbrw_pkg::*;
#(
    parameter int unsigned MAX_MBS = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    mbrw_sample_if.sink          samples,
    mbrw_raster_if.source        pixels
);

    localparam int unsigned CW = (MAX_MBS > 1) ? $clog2(MAX_MBS) : 1;

    logic [CFG_W-1:0]   picture_width_reg;
    logic [CFG_W-1:0]   picture_height_reg;
    logic [CFG_W-1:0]   line_stride_reg;
    logic [CW-1:0]      mb_column;
    logic [CW-1:0]      mb_row;
    mbrw_pos_t          pos;
    logic [ADDR_W-1:0]  address;
    logic               step;
    logic               out_valid_reg, out_valid_next;
    logic [PLANE_W-1:0] plane_reg;
    logic [ADDR_W-1:0]  address_reg;
    logic [PIX_W-1:0]   pixel_reg;
    logic               frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            picture_width_reg  <= CFG_W'(1);
            picture_height_reg <= CFG_W'(1);
            line_stride_reg    <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PICTURE_WIDTH:  picture_width_reg  <= cfg_data;
                REG_PICTURE_HEIGHT: picture_height_reg <= cfg_data;
                REG_LINE_STRIDE:    line_stride_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    mbrw_position #(
        .MAX_MBS (MAX_MBS)
    ) u_position (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .picture_width_mbs  (picture_width_reg),
        .picture_height_mbs (picture_height_reg),
        .mb_column          (mb_column),
        .mb_row             (mb_row),
        .pos                (pos)
    );

    mbrw_address #(
        .MAX_MBS (MAX_MBS)
    ) u_address (
        .mb_column       (mb_column),
        .mb_row          (mb_row),
        .line_stride_mbs (line_stride_reg),
        .pos             (pos),
        .buffer_address  (address)
    );

    assign samples.ready = !out_valid_reg || pixels.ready;
    assign step          = samples.valid && samples.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (pixels.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            plane_reg     <= pos.plane;
            address_reg   <= address;
            pixel_reg     <= samples.sample_byte;
            frame_end_reg <= pos.frame_end;
        end
    end

    assign pixels.valid          = out_valid_reg;
    assign pixels.plane          = plane_reg;
    assign pixels.buffer_address = address_reg;
    assign pixels.pixel_value    = pixel_reg;
    assign pixels.frame_end      = frame_end_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pixels.ready |-> !step)
        else $error("sample taken while result still held");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("no result after sample transaction");

    a_plane_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (plane_reg == PLANE_LUMA || plane_reg == PLANE_CB
                           || plane_reg == PLANE_CR))
        else $error("unused plane code on output");

endmodule
